>>> hdl/cpl_pkg.sv
package cpl_pkg;

    // fraction bits kept in the line parameters s and t
    localparam int unsigned FRAC_S = 16;

    // determinant threshold register
    localparam int unsigned THR_BITS = 32;
    localparam logic [THR_BITS-1:0] THR_RESET = 32'd1;

    // per-item flags that ride along the pipeline next to the data
    typedef struct packed {
        logic non_parallel;
        logic det_zero;
    } t_flags;

endpackage

>>> hdl/cpl_wmul.sv
// two-stage signed multiplier built from four narrow partial products
module cpl_wmul #(
    parameter int AW = 35
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [AW-1:0]   i_x,
    input  logic signed [AW-1:0]   i_y,
    output logic signed [2*AW-1:0] o_p
);
    localparam int H  = (AW + 1) / 2;
    localparam int HW = AW - H;
    localparam int PW = 2 * AW;

    logic signed [HW-1:0]      x_hi, y_hi;
    logic        [H-1:0]       x_lo, y_lo;
    logic signed [2*HW-1:0]    r_hh;
    logic signed [HW+H:0]      r_hl, r_lh;
    logic        [2*H-1:0]     r_ll;
    logic signed [PW-1:0]      e_hh, e_hl, e_lh, e_ll;
    logic signed [PW-1:0]      r_p;

    function automatic logic signed [HW-1:0] x_hi_sel(input logic signed [AW-1:0] v);
        x_hi_sel = v[AW-1:H];
    endfunction

    assign x_hi = x_hi_sel(i_x);
    assign y_hi = x_hi_sel(i_y);
    assign x_lo = i_x[H-1:0];
    assign y_lo = i_y[H-1:0];

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= x_hi * y_hi;
            r_hl <= x_hi * $signed({1'b0, y_lo});
            r_lh <= $signed({1'b0, x_lo}) * y_hi;
            r_ll <= x_lo * y_lo;
        end
    end

    assign e_hh = PW'(r_hh);
    assign e_hl = PW'(r_hl);
    assign e_lh = PW'(r_lh);
    assign e_ll = PW'($signed({1'b0, r_ll}));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (e_hh <<< (2 * H)) + (e_hl <<< H) + (e_lh <<< H) + e_ll;
        end
    end

    assign o_p = r_p;

endmodule

>>> hdl/cpl_div.sv
// pipelined restoring divider: |num| * 2^FRAC_S / den, one quotient bit per stage,
// clamped to 2^(QB-1)
module cpl_div #(
    parameter int NW = 70,
    parameter int QB = 34
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW-1:0] i_num,
    input  logic        [NW-1:0] i_den,
    output logic        [QB-1:0] o_mag,
    output logic                 o_neg
);
    localparam int RW = NW - 1 + cpl_pkg::FRAC_S;
    localparam int CW = NW + QB;
    localparam logic [QB-1:0] LIM = QB'(1) << (QB - 1);

    logic [NW-1:0] num_abs;
    logic [RW-1:0] rem0;
    logic          ovf0;

    logic [RW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [NW-1:0] r_den [QB];
    logic          r_neg [QB+1];
    logic          r_ovf [QB+1];
    logic [QB-1:0] r_res;
    logic          r_rneg;

    assign num_abs = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    assign rem0    = {num_abs[NW-2:0], {cpl_pkg::FRAC_S{1'b0}}};
    assign ovf0    = CW'(rem0) >= {i_den, {QB{1'b0}}};

    // prep: magnitude, fraction shift, out-of-range check
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= rem0;
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_num[NW-1];
            r_ovf[0] <= ovf0;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int K = QB - 1 - j;
        logic [CW-1:0] dsh;
        logic [CW-1:0] rem_c;
        logic          ge;

        assign dsh   = CW'(r_den[j]) << K;
        assign rem_c = CW'(r_rem[j]);
        assign ge    = rem_c >= dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= ge ? RW'(rem_c - dsh) : r_rem[j];
                r_q[j+1]   <= r_q[j] | (ge ? (QB'(1) << K) : '0);
                r_neg[j+1] <= r_neg[j];
                r_ovf[j+1] <= r_ovf[j];
            end
        end

        if (j + 1 < QB) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[j+1] <= r_den[j];
                end
            end
        end
    end

    // clamp
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res  <= (r_ovf[QB] || (r_q[QB] > LIM)) ? LIM : r_q[QB];
            r_rneg <= r_neg[QB];
        end
    end

    assign o_mag = r_res;
    assign o_neg = r_rneg;

endmodule

>>> hdl/cpl_place.sv
// one coordinate: base + param * dir, scaled back and saturated; base alone when i_zero is set
module cpl_place #(
    parameter int N  = 16,
    parameter int QB = 34
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [QB-1:0]       i_mag,
    input  logic                i_neg,
    input  logic signed [N:0]   i_dir,
    input  logic signed [N-1:0] i_base,
    input  logic                i_zero,
    output logic signed [N-1:0] o_coord,
    output logic                o_clip
);
    localparam int PW   = QB + N;
    localparam int OW   = PW - cpl_pkg::FRAC_S;
    localparam int SUMW = OW + 2;
    localparam logic signed [SUMW-1:0] HI = SUMW'((64'sd1 <<< (N - 1)) - 64'sd1);
    localparam logic signed [SUMW-1:0] LO = -HI - SUMW'(1);

    logic [N:0]             dir_neg;
    logic [N-1:0]           dir_mag;
    logic [PW-1:0]          r_prod;
    logic                   r_sneg;
    logic signed [N-1:0]    r_base;
    logic                   r_zero;
    logic signed [SUMW-1:0] off, soff, sum;
    logic                   hi_sat, lo_sat;

    assign dir_neg = -i_dir;
    assign dir_mag = i_dir[N] ? dir_neg[N-1:0] : i_dir[N-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_mag * dir_mag;
            r_sneg <= i_neg ^ i_dir[N];
            r_base <= i_base;
            r_zero <= i_zero;
        end
    end

    assign off    = $signed({2'b00, r_prod[PW-1:cpl_pkg::FRAC_S]});
    assign soff   = r_sneg ? -off : off;
    assign sum    = SUMW'(r_base) + soff;
    assign hi_sat = sum > HI;
    assign lo_sat = sum < LO;

    always_comb begin
        if (r_zero) begin
            o_coord = r_base;
        end else if (hi_sat) begin
            o_coord = HI[N-1:0];
        end else if (lo_sat) begin
            o_coord = LO[N-1:0];
        end else begin
            o_coord = sum[N-1:0];
        end
    end

    assign o_clip = !r_zero && (hi_sat || lo_sat);

endmodule

>>> hdl/closest_points_two_lines.sv
// Nearest points between two 3D lines. Each input beat carries line A (P0, P1) and line B
// (Q0, Q1) as signed fixed-point coordinates with 8 fraction bits; each output beat gives the
// point on A nearest B and the point on B nearest A, saturated to the coordinate range, plus
// non_parallel (determinant D >= det_threshold, D in units of 2^-32) and clipped (any
// coordinate saturated). When D is exactly zero the block returns P0 and Q0 unchanged.
// The block takes one beat per clock unless stalled; the pipeline depth is set by the
// restoring divider for s and t, which resolves one quotient bit per stage. A full output
// register that is not taken stalls the whole pipeline, but bubbles ahead of it still drain.
module closest_points_two_lines #(
    parameter int COORD_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config
    input  logic                    i_cfg_we,
    input  logic [31:0]             i_cfg_wdata,     // det_threshold
    // input lines
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // line_a_start_x/y/z, line_a_end_x/y/z, line_b_start_x/y/z, line_b_end_x/y/z
    input  logic [((12*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // nearest points
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // near_a_x/y/z, near_b_x/y/z
    output logic [((6*COORD_BITS+7)/8)*8-1:0]  o_m_axis_tdata,
    // non_parallel, clipped
    output logic [1:0]              o_m_axis_tuser
);
    localparam int N      = COORD_BITS;
    localparam int OUT_W  = ((6 * N + 7) / 8) * 8;
    localparam int PRW    = 2 * N + 2;        // product of two differences
    localparam int SW     = 2 * N + 3;        // dot product
    localparam int NW     = 2 * SW;           // determinant and numerators
    localparam int QB     = N + 18;           // quotient bits, clamp at 2^(N+17)
    localparam int SD     = QB + 8;           // side data delay
    localparam int FD     = QB + 4;           // flag delay
    localparam int VD     = QB + 9;           // valid chain up to the stage before output

    // pipeline control
    logic en, out_en, pre_valid;

    // config
    logic [cpl_pkg::THR_BITS-1:0] r_thr;

    // side data: start points and directions, stage 1 onward
    logic signed [N-1:0] r_sp0 [SD][3];
    logic signed [N-1:0] r_sq0 [SD][3];
    logic signed [N:0]   r_su  [SD][3];
    logic signed [N:0]   r_sv  [SD][3];
    logic signed [N:0]   r_w   [3];

    logic [VD-1:0] r_vld;

    // products and dot products: a=u.u b=u.v c=v.v d=u.w e=v.w
    logic signed [PRW-1:0] r_pr [5][3];
    logic signed [SW-1:0]  r_dot [5];

    // wide products
    logic signed [NW-1:0] p_ac, p_bb, p_be, p_cd, p_ae, p_bd;
    logic signed [NW-1:0] n_den;

    logic signed [NW-1:0] r_den, r_ns, r_nt;
    cpl_pkg::t_flags      r_flg [FD];

    // divider results
    logic [QB-1:0] s_mag, t_mag;
    logic          s_neg, t_neg;

    // placed coordinates
    logic signed [N-1:0] crd [6];
    logic [5:0]          clp;

    // output register
    logic            r_out_valid;
    logic [6*N-1:0]  r_out_data;
    logic [1:0]      r_out_user;

    // the output register loads when empty or taken; the rest of the pipe
    // may still move when the beat in front of the output is a bubble
    assign pre_valid       = r_vld[VD-1];
    assign out_en          = !r_out_valid || i_m_axis_tready;
    assign en              = out_en || !pre_valid;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= cpl_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[VD-2:0], i_s_axis_tvalid};
        end
    end

    // stage 1: unpack and form u, v, w; side data shift line behind it
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sp0[0][i] <= $signed(i_s_axis_tdata[i*N +: N]);
                r_sq0[0][i] <= $signed(i_s_axis_tdata[(6+i)*N +: N]);
                r_su[0][i]  <= (N+1)'($signed(i_s_axis_tdata[(3+i)*N +: N]))
                             - (N+1)'($signed(i_s_axis_tdata[i*N +: N]));
                r_sv[0][i]  <= (N+1)'($signed(i_s_axis_tdata[(9+i)*N +: N]))
                             - (N+1)'($signed(i_s_axis_tdata[(6+i)*N +: N]));
                r_w[i]      <= (N+1)'($signed(i_s_axis_tdata[i*N +: N]))
                             - (N+1)'($signed(i_s_axis_tdata[(6+i)*N +: N]));
            end
            for (int k = 1; k < SD; k++) begin
                r_sp0[k] <= r_sp0[k-1];
                r_sq0[k] <= r_sq0[k-1];
                r_su[k]  <= r_su[k-1];
                r_sv[k]  <= r_sv[k-1];
            end
        end
    end

    // stage 2: component products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_pr[0][i] <= r_su[0][i] * r_su[0][i];
                r_pr[1][i] <= r_su[0][i] * r_sv[0][i];
                r_pr[2][i] <= r_sv[0][i] * r_sv[0][i];
                r_pr[3][i] <= r_su[0][i] * r_w[i];
                r_pr[4][i] <= r_sv[0][i] * r_w[i];
            end
        end
    end

    // stage 3: dot products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int m = 0; m < 5; m++) begin
                r_dot[m] <= SW'(r_pr[m][0]) + SW'(r_pr[m][1]) + SW'(r_pr[m][2]);
            end
        end
    end

    // stages 4-5: the six wide products
    cpl_wmul #(.AW(SW)) u_mul_ac (
        .i_clk(i_clk), .i_en(en), .i_x(r_dot[0]), .i_y(r_dot[2]), .o_p(p_ac)
    );
    cpl_wmul #(.AW(SW)) u_mul_bb (
        .i_clk(i_clk), .i_en(en), .i_x(r_dot[1]), .i_y(r_dot[1]), .o_p(p_bb)
    );
    cpl_wmul #(.AW(SW)) u_mul_be (
        .i_clk(i_clk), .i_en(en), .i_x(r_dot[1]), .i_y(r_dot[4]), .o_p(p_be)
    );
    cpl_wmul #(.AW(SW)) u_mul_cd (
        .i_clk(i_clk), .i_en(en), .i_x(r_dot[2]), .i_y(r_dot[3]), .o_p(p_cd)
    );
    cpl_wmul #(.AW(SW)) u_mul_ae (
        .i_clk(i_clk), .i_en(en), .i_x(r_dot[0]), .i_y(r_dot[4]), .o_p(p_ae)
    );
    cpl_wmul #(.AW(SW)) u_mul_bd (
        .i_clk(i_clk), .i_en(en), .i_x(r_dot[1]), .i_y(r_dot[3]), .o_p(p_bd)
    );

    // stage 6: determinant, numerators, threshold compare
    // D = ac - b^2 is never negative, so it compares as unsigned
    assign n_den = p_ac - p_bb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den                <= n_den;
            r_ns                 <= p_be - p_cd;
            r_nt                 <= p_ae - p_bd;
            r_flg[0].non_parallel <= $unsigned(n_den) >= NW'(r_thr);
            r_flg[0].det_zero     <= n_den == '0;
            for (int k = 1; k < FD; k++) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    // s and t
    cpl_div #(.NW(NW), .QB(QB)) u_div_s (
        .i_clk(i_clk), .i_en(en), .i_num(r_ns), .i_den($unsigned(r_den)),
        .o_mag(s_mag), .o_neg(s_neg)
    );
    cpl_div #(.NW(NW), .QB(QB)) u_div_t (
        .i_clk(i_clk), .i_en(en), .i_num(r_nt), .i_den($unsigned(r_den)),
        .o_mag(t_mag), .o_neg(t_neg)
    );

    // P0 + s*u and Q0 + t*v per axis
    for (genvar i = 0; i < 3; i++) begin : g_axis
        cpl_place #(.N(N), .QB(QB)) u_place_a (
            .i_clk(i_clk), .i_en(en), .i_mag(s_mag), .i_neg(s_neg),
            .i_dir(r_su[SD-1][i]), .i_base(r_sp0[SD-1][i]),
            .i_zero(r_flg[FD-2].det_zero),
            .o_coord(crd[i]), .o_clip(clp[i])
        );
        cpl_place #(.N(N), .QB(QB)) u_place_b (
            .i_clk(i_clk), .i_en(en), .i_mag(t_mag), .i_neg(t_neg),
            .i_dir(r_sv[SD-1][i]), .i_base(r_sq0[SD-1][i]),
            .i_zero(r_flg[FD-2].det_zero),
            .o_coord(crd[3+i]), .o_clip(clp[3+i])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= pre_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_data <= {crd[5], crd[4], crd[3], crd[2], crd[1], crd[0]};
            r_out_user <= {|clp, r_flg[FD-1].non_parallel};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_data);
    assign o_m_axis_tuser  = r_out_user;

    // input is refused only behind a held result
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without a held output beat");

    // a beat waiting behind a held result is kept
    a_pre_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pre_valid && o_m_axis_tvalid && !i_m_axis_tready) |=> pre_valid)
        else $error("beat lost in front of the output register");

    // reset empties the output register
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule
